// ----- rtl/affr_pkg.sv -----
// Shared types, constants and lookup functions for the audio file framer.
package affr_pkg;

  localparam int FIXED_FRAME_BYTES = 160;
  localparam int COUNT_BITS = 16;
  localparam int OUT_CNT_W = 16;
  localparam int FIX_IDX_W = (FIXED_FRAME_BYTES > 1) ? $clog2(FIXED_FRAME_BYTES) : 1;
  localparam int HELD_DEPTH = 8;
  localparam int HELD_IDX_W = $clog2(HELD_DEPTH);

  localparam logic [3:0] MAGIC_LEN = 4'd9;
  localparam logic [3:0] TYPE_RESV_LO = 4'd10;
  localparam logic [3:0] TYPE_RESV_HI = 4'd13;
  localparam logic [3:0] TYPE_NO_DATA = 4'd15;

  localparam int PADDR_W = 3;
  localparam logic REG_IDX_CODEC_MODE = 1'b0;

  typedef enum logic {
    MODE_FIXED = 1'b0,
    MODE_AMR   = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_TYPE  = 3'd1,
    STAT_TRUNC     = 3'd2,
    STAT_NO_FRAMES = 3'd3,
    STAT_BAD_SIZE  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       no_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 byte_valid;
    logic                 frame_start;
    logic                 frame_end;
    logic [3:0]           frame_type;
    logic                 no_data_frame;
    logic [OUT_CNT_W-1:0] frame_number;
    logic                 stream_done;
    status_e              status;
    logic [OUT_CNT_W-1:0] frame_count;
  } out_item_t;

  // Storage-format magic "#!AMR-WB\n", one character per position.
  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h23;
      4'd1:    b = 8'h21;
      4'd2:    b = 8'h41;
      4'd3:    b = 8'h4D;
      4'd4:    b = 8'h52;
      4'd5:    b = 8'h2D;
      4'd6:    b = 8'h57;
      4'd7:    b = 8'h42;
      4'd8:    b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Speech payload bytes that follow the ToC byte, per frame type.
  function automatic logic [5:0] amr_payload_len(input logic [3:0] ft);
    logic [5:0] n;
    case (ft)
      4'd0:    n = 6'd17;
      4'd1:    n = 6'd23;
      4'd2:    n = 6'd32;
      4'd3:    n = 6'd36;
      4'd4:    n = 6'd40;
      4'd5:    n = 6'd46;
      4'd6:    n = 6'd50;
      4'd7:    n = 6'd58;
      4'd8:    n = 6'd60;
      4'd9:    n = 6'd5;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic logic [OUT_CNT_W-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
    localparam int WIDE_W = COUNT_BITS + OUT_CNT_W;
    logic [WIDE_W-1:0] vw;
    logic [WIDE_W-1:0] lim;
    vw  = WIDE_W'(v);
    lim = WIDE_W'({OUT_CNT_W{1'b1}});
    return (vw > lim) ? {OUT_CNT_W{1'b1}} : vw[OUT_CNT_W-1:0];
  endfunction

endpackage

// ----- rtl/audio_file_framer.sv -----
// Top level of the audio file framer: config register and channel stages.
//
// Bytes of a media file enter on the input channel, one word each, with
// flags for a byteless word and for the end of the stream. Every frame byte
// leaves as one result word carrying frame start/end marks, type (AMR-WB
// only) and frame number; the last result of a stream carries stream_done,
// the final status and the frame count. codec_mode selects fixed framing or
// AMR-WB storage format; writing it restarts the stream state. Writing is to
// be done between streams; the block itself does not enforce it. A word
// accepted into the input register has its result loaded into the output
// register. One word is taken per cycle in steady state, while the receiver
// does not stall and no held bytes are replayed. After a magic mismatch, and
// when a stream ends on a partial magic, the single parse step replays the
// hold buffer while the word waits; a mismatching byte is parsed after the
// replay. Reset clears all control state and returns codec_mode to fixed
// framing; there is no clearing pass. A stall from the receiver holds the
// output register; the next word still parses if it yields no result,
// otherwise the input register holds it and stalls the sender.
module audio_file_framer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [affr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  affr_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output affr_pkg::out_item_t           out_item_o
);
  import affr_pkg::*;

  mode_e     codec_mode_q;
  logic      cfg_we;
  logic      core_valid;
  in_item_t  core_item;
  logic      core_pop;
  logic      out_free;
  logic      out_load;
  out_item_t core_res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_IDX_CODEC_MODE);
  assign prdata = (paddr[PADDR_W-1] == REG_IDX_CODEC_MODE) ?
                  {31'b0, codec_mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_mode_q <= MODE_FIXED;
    end else if (cfg_we) begin
      codec_mode_q <= mode_e'(pwdata[0]);
    end
  end

  affr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .pop_i      (core_pop),
    .valid_o    (core_valid),
    .item_o     (core_item)
  );

  affr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (codec_mode_q),
    .cfg_clear_i (cfg_we),
    .in_valid_i  (core_valid),
    .in_item_i   (core_item),
    .pop_o       (core_pop),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .out_item_o  (core_res)
  );

  affr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .item_i      (core_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- rtl/affr_in_stage.sv -----
// Input register: holds one accepted word until the framing core retires it.
module affr_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  affr_pkg::in_item_t in_item_i,
  input  logic              pop_i,
  output logic              valid_o,
  output affr_pkg::in_item_t item_o
);
  import affr_pkg::*;

  logic     valid_q;
  in_item_t item_q;
  logic     load;

  // A held word blocks the channel until it is retired in this cycle.
  assign in_stall_o = valid_q && !pop_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/affr_out_stage.sv -----
// Output register: one result word towards the receiver.
module affr_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  affr_pkg::out_item_t item_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output affr_pkg::out_item_t out_item_o
);
  import affr_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ----- rtl/affr_core.sv -----
// Framing core: stream state, magic hold buffer and the per-word parse step.
module affr_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  affr_pkg::mode_e    mode_i,
  input  logic               cfg_clear_i,
  input  logic               in_valid_i,
  input  affr_pkg::in_item_t in_item_i,
  output logic               pop_o,
  input  logic               out_free_i,
  output logic               out_load_o,
  output affr_pkg::out_item_t out_item_o
);
  import affr_pkg::*;

  logic [3:0]            match_cnt_q, match_cnt_d;
  logic                  header_q, header_d;
  logic [5:0]            payload_left_q, payload_left_d;
  logic [FIX_IDX_W-1:0]  fix_idx_q, fix_idx_d;
  logic [3:0]            cur_type_q, cur_type_d;
  logic [COUNT_BITS-1:0] frames_q, frames_d;
  logic                  bytes_seen_q, bytes_seen_d;
  status_e               err_q, err_d;
  logic                  rep_active_q, rep_active_d;
  logic [HELD_IDX_W-1:0] rep_idx_q, rep_idx_d;
  logic                  byte_done_q, byte_done_d;

  logic [7:0]            held_q [HELD_DEPTH];
  logic                  held_we;

  logic                  has_byte;
  logic [7:0]            pb;
  logic [3:0]            ft;
  logic                  toc;
  logic                  ft_bad;
  logic [5:0]            plen;
  logic [5:0]            amr_left;
  logic                  amr_end;
  logic                  amr_emit;
  logic                  amr_err_set;
  logic [COUNT_BITS-1:0] frames_inc;
  logic                  fix_end;
  logic                  use_amr;
  logic                  emit;
  logic                  item_done;
  logic                  step_go;
  status_e               fin_err;
  out_item_t             res;

  assign has_byte = !in_item_i.no_byte && !byte_done_q;

  // Replay reads the held prefix, everything else parses the word's byte.
  assign pb          = rep_active_q ? held_q[rep_idx_q] : in_item_i.data_byte;
  assign ft          = pb[6:3];
  assign toc         = (payload_left_q == '0);
  assign ft_bad      = (ft >= TYPE_RESV_LO) && (ft <= TYPE_RESV_HI);
  assign plen        = amr_payload_len(ft);
  assign amr_left    = toc ? plen : (payload_left_q - 6'd1);
  assign amr_end     = (amr_left == '0);
  assign amr_err_set = (err_q == STAT_OK) && toc && ft_bad;
  assign amr_emit    = (err_q == STAT_OK) && !(toc && ft_bad);
  assign frames_inc  = (&frames_q) ? frames_q : (frames_q + 1'b1);
  assign fix_end     = (fix_idx_q == FIX_IDX_W'(FIXED_FRAME_BYTES - 1));

  always_comb begin
    match_cnt_d    = match_cnt_q;
    header_d       = header_q;
    payload_left_d = payload_left_q;
    fix_idx_d      = fix_idx_q;
    cur_type_d     = cur_type_q;
    frames_d       = frames_q;
    bytes_seen_d   = bytes_seen_q;
    err_d          = err_q;
    rep_active_d   = rep_active_q;
    rep_idx_d      = rep_idx_q;
    byte_done_d    = byte_done_q;
    held_we        = 1'b0;
    use_amr        = 1'b0;
    emit           = 1'b0;
    item_done      = 1'b0;
    fin_err        = STAT_OK;
    res            = '0;
    res.status     = err_q;

    if (in_valid_i) begin
      if (rep_active_q) begin
        use_amr   = 1'b1;
        rep_idx_d = rep_idx_q + 1'b1;
        if ({1'b0, rep_idx_q} == (match_cnt_q - 4'd1)) begin
          // Last held byte: leave the header, then parse the word's own byte if any.
          rep_active_d = 1'b0;
          rep_idx_d    = '0;
          match_cnt_d  = '0;
          header_d     = 1'b0;
          item_done    = !has_byte;
        end
      end else if (has_byte) begin
        bytes_seen_d = 1'b1;
        if (mode_i == MODE_FIXED) begin
          emit              = 1'b1;
          item_done         = 1'b1;
          res.out_byte      = pb;
          res.byte_valid    = 1'b1;
          res.frame_start   = (fix_idx_q == '0);
          res.frame_end     = fix_end;
          res.frame_number  = sat_out(frames_q);
          if (fix_end) begin
            fix_idx_d = '0;
            frames_d  = frames_inc;
          end else begin
            fix_idx_d = fix_idx_q + 1'b1;
          end
        end else if (header_q) begin
          if ((match_cnt_q < MAGIC_LEN) && (pb == magic_byte(match_cnt_q))) begin
            held_we = (match_cnt_q < 4'(HELD_DEPTH));
            if (match_cnt_q == (MAGIC_LEN - 4'd1)) begin
              match_cnt_d = '0;
              header_d    = 1'b0;
              item_done   = 1'b1;
            end else begin
              match_cnt_d = match_cnt_q + 4'd1;
              // Stream ends on a partial magic: hold the word and replay next.
              if (in_item_i.end_of_stream) begin
                byte_done_d = 1'b1;
              end else begin
                item_done = 1'b1;
              end
            end
          end else if (match_cnt_q == '0) begin
            header_d  = 1'b0;
            use_amr   = 1'b1;
            item_done = 1'b1;
          end else begin
            rep_active_d = 1'b1;
            rep_idx_d    = '0;
          end
        end else begin
          use_amr   = 1'b1;
          item_done = 1'b1;
        end
      end else if (in_item_i.end_of_stream && (mode_i == MODE_AMR) && header_q &&
                   (match_cnt_q != '0)) begin
        rep_active_d = 1'b1;
        rep_idx_d    = '0;
      end else begin
        item_done = 1'b1;
      end

      if (use_amr) begin
        if (amr_err_set) begin
          err_d = STAT_BAD_TYPE;
        end
        if (amr_emit) begin
          emit             = 1'b1;
          payload_left_d   = amr_left;
          cur_type_d       = toc ? ft : cur_type_q;
          if (amr_end) begin
            frames_d = frames_inc;
          end
          res.out_byte      = pb;
          res.byte_valid    = !(toc && (ft == TYPE_NO_DATA));
          res.frame_start   = toc;
          res.frame_end     = amr_end;
          res.frame_type    = toc ? ft : cur_type_q;
          res.no_data_frame = toc && (ft == TYPE_NO_DATA);
          res.frame_number  = sat_out(frames_q);
        end
      end

      if (item_done && in_item_i.end_of_stream) begin
        fin_err = err_d;
        if (err_d == STAT_OK) begin
          if (mode_i == MODE_AMR) begin
            if (payload_left_d != '0) begin
              fin_err = STAT_TRUNC;
            end else if (frames_d == '0) begin
              fin_err = STAT_NO_FRAMES;
            end
          end else if (!bytes_seen_d || (fix_idx_d != '0)) begin
            fin_err = STAT_BAD_SIZE;
          end
        end
        if (!emit) begin
          res              = '0;
          res.frame_number = sat_out(frames_d);
        end
        emit            = 1'b1;
        res.stream_done = 1'b1;
        res.status      = fin_err;
        res.frame_count = sat_out(frames_d);
        // Drop all stream state back to its reset value.
        match_cnt_d    = '0;
        header_d       = 1'b1;
        payload_left_d = '0;
        fix_idx_d      = '0;
        cur_type_d     = '0;
        frames_d       = '0;
        bytes_seen_d   = 1'b0;
        err_d          = STAT_OK;
        rep_active_d   = 1'b0;
        rep_idx_d      = '0;
      end

      if (item_done) begin
        byte_done_d = 1'b0;
      end
    end
  end

  assign step_go    = in_valid_i && (!emit || out_free_i);
  assign pop_o      = step_go && item_done;
  assign out_load_o = step_go && emit;
  assign out_item_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_cnt_q    <= '0;
      header_q       <= 1'b1;
      payload_left_q <= '0;
      fix_idx_q      <= '0;
      cur_type_q     <= '0;
      frames_q       <= '0;
      bytes_seen_q   <= 1'b0;
      err_q          <= STAT_OK;
      rep_active_q   <= 1'b0;
      rep_idx_q      <= '0;
      byte_done_q    <= 1'b0;
    end else if (cfg_clear_i) begin
      match_cnt_q    <= '0;
      header_q       <= 1'b1;
      payload_left_q <= '0;
      fix_idx_q      <= '0;
      cur_type_q     <= '0;
      frames_q       <= '0;
      bytes_seen_q   <= 1'b0;
      err_q          <= STAT_OK;
      rep_active_q   <= 1'b0;
      rep_idx_q      <= '0;
      byte_done_q    <= 1'b0;
    end else if (step_go) begin
      match_cnt_q    <= match_cnt_d;
      header_q       <= header_d;
      payload_left_q <= payload_left_d;
      fix_idx_q      <= fix_idx_d;
      cur_type_q     <= cur_type_d;
      frames_q       <= frames_d;
      bytes_seen_q   <= bytes_seen_d;
      err_q          <= err_d;
      rep_active_q   <= rep_active_d;
      rep_idx_q      <= rep_idx_d;
      byte_done_q    <= byte_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && held_we) begin
      held_q[match_cnt_q[HELD_IDX_W-1:0]] <= pb;
    end
  end

  a_rep_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_active_q |-> (header_q && (match_cnt_q != '0) && (mode_i == MODE_AMR)))
    else $error("replay outside a partly matched magic");

  a_rep_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_active_q |-> ({1'b0, rep_idx_q} < match_cnt_q))
    else $error("replay index beyond held bytes");

  a_byte_done_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_done_q |-> (in_valid_i && in_item_i.end_of_stream && !in_item_i.no_byte))
    else $error("consumed byte flag without its end-of-stream word");

  a_match_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_cnt_q < MAGIC_LEN)
    else $error("magic match count out of range");

endmodule
